@@ sv/fbuf_pkg.sv @@
// shared types, constants and helpers for the two-line instruction fetch buffer
// no dependencies; imported by fbuf_core and the top level
package fbuf_pkg;

    localparam int ADDR_W    = 32;
    localparam int LINE_W    = 64;
    localparam int WORD_W    = 32;
    localparam int HALF_W    = 16;
    localparam int OFF_W     = 3;
    localparam int TAG_W     = ADDR_W - OFF_W;
    localparam int SEL_W     = 2;
    localparam int ST_W      = 2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [LINE_W-1:0] t_line;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SEL_W-1:0]  t_sel;
    typedef logic [ST_W-1:0]   t_state;

    localparam t_state ST_IDLE        = 2'd0;
    localparam t_state ST_WAIT_GRANT  = 2'd1;
    localparam t_state ST_WAIT_RESP   = 2'd2;
    localparam t_state ST_WAIT_ACCEPT = 2'd3;

    // halfword offsets inside a line
    localparam t_sel SEL_LO       = 2'd0;
    localparam t_sel SEL_MID      = 2'd1;
    localparam t_sel SEL_HI       = 2'd2;
    localparam t_sel SEL_STRADDLE = 2'd3;

    localparam t_tag  TAG_RESET = '1;
    localparam t_addr ADDR_STEP = t_addr'(2);

    typedef struct packed {
        logic  fetch_valid;
        t_addr fetch_addr;
        logic  mem_grant;
        logic  mem_resp_valid;
        t_line mem_resp_data;
        logic  fetch_resp_ready;
    } t_in_item;

    typedef struct packed {
        logic   fetch_ready;
        logic   mem_req_valid;
        t_addr  mem_req_addr;
        logic   resp_valid;
        t_word  resp_data;
        t_addr  resp_addr;
        t_state fsm_state;
    } t_out_item;

    // 32-bit word at halfword offset sel of lo, straddling into hi at the last offset
    function automatic t_word pick_word(input t_line lo, input t_line hi, input t_sel sel);
        t_word w;
        unique case (sel)
            SEL_LO:   w = lo[31:0];
            SEL_MID:  w = lo[47:16];
            SEL_HI:   w = lo[63:32];
            default:  w = {hi[HALF_W-1:0], lo[63:48]};
        endcase
        return w;
    endfunction

    function automatic t_addr line_base(input t_addr a);
        return {a[ADDR_W-1:OFF_W], OFF_W'(0)};
    endfunction

endpackage

@@ sv/fbuf_core.sv @@
// line store, handshake state machine and next-state logic
// depends on fbuf_pkg; state advances only when i_en is high
module fbuf_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fbuf_pkg::t_in_item  i_item,
    output fbuf_pkg::t_out_item o_item
);
    import fbuf_pkg::*;

    t_tag   r_tag  [2];
    t_line  r_word [2];
    t_addr  r_pend;
    t_addr  r_cur;
    t_state r_state;
    logic   r_second;
    logic   r_held_vld;
    t_word  r_held_word;

    t_tag   n_tag  [2];
    t_line  n_word [2];
    t_addr  n_pend;
    t_addr  n_cur;
    t_state n_state;
    logic   n_second;
    logic   n_held_vld;
    t_word  n_held_word;

    // lookup addresses: request, request+2, current, current+2
    t_addr  la [4];
    logic   m0 [4];
    logic   m1 [4];
    logic   mp [4];
    t_line  ld [4];

    t_tag   pend_tag;
    logic   wait_resp;
    logic   req_valid;
    logic   hit0;
    logic   hit1;
    logic   need_mem;
    logic   mem_valid;
    t_addr  mem_addr;
    logic   fready;
    logic   fire;
    logic   reuse;
    t_state after_req;

    assign pend_tag  = r_pend[ADDR_W-1:OFF_W];
    assign wait_resp = (r_state == ST_WAIT_RESP) && !i_item.mem_resp_valid;
    assign req_valid = !wait_resp && (i_item.fetch_valid || r_second);

    assign la[0] = i_item.fetch_addr;
    assign la[1] = i_item.fetch_addr + ADDR_STEP;
    assign la[2] = r_cur;
    assign la[3] = r_cur + ADDR_STEP;

    // priority: slot 0, slot 1, then the line on its way from memory
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            m0[k] = la[k][ADDR_W-1:OFF_W] == r_tag[0];
            m1[k] = !m0[k] && (la[k][ADDR_W-1:OFF_W] == r_tag[1]);
            mp[k] = !m0[k] && !m1[k] && (la[k][ADDR_W-1:OFF_W] == pend_tag);
            if (m0[k]) begin
                ld[k] = r_word[0];
            end else if (m1[k]) begin
                ld[k] = r_word[1];
            end else if (mp[k]) begin
                ld[k] = i_item.mem_resp_data;
            end else begin
                ld[k] = '0;
            end
        end
    end

    assign hit0 = ((m0[0] || m1[0]) && req_valid) || (mp[0] && i_item.mem_resp_valid);
    assign hit1 = ((m0[1] || m1[1]) && req_valid) || (mp[1] && i_item.mem_resp_valid);
    assign need_mem  = !(hit0 && hit1);
    assign mem_valid = need_mem && req_valid;
    assign fready    = !need_mem || (i_item.mem_grant && !wait_resp);
    assign fire      = req_valid && fready;

    always_comb begin
        priority if (r_second) begin
            mem_addr = line_base(la[3]);
        end else if (!hit0) begin
            mem_addr = line_base(la[0]);
        end else begin
            mem_addr = line_base(la[1]);
        end
    end

    assign after_req = !need_mem ? ST_WAIT_ACCEPT :
                       (i_item.mem_grant ? ST_WAIT_RESP : ST_WAIT_GRANT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_valid) n_state = after_req;
            end
            ST_WAIT_GRANT: begin
                if (i_item.mem_grant) begin
                    n_state = ST_WAIT_RESP;
                end else if (!need_mem) begin
                    n_state = ST_WAIT_ACCEPT;
                end
            end
            ST_WAIT_RESP: begin
                if (i_item.mem_resp_valid) begin
                    if (!i_item.fetch_resp_ready) begin
                        n_state = ST_WAIT_ACCEPT;
                    end else if (!req_valid) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = after_req;
                    end
                end
            end
            default: begin
                if (i_item.fetch_resp_ready) begin
                    n_state = req_valid ? after_req : ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_held_vld  = r_held_vld;
        n_held_word = r_held_word;
        if (req_valid && !need_mem) begin
            n_held_vld  = 1'b1;
            n_held_word = pick_word(ld[0], ld[1], i_item.fetch_addr[OFF_W-1:1]);
        end else if (i_item.fetch_resp_ready) begin
            n_held_vld  = 1'b0;
            n_held_word = '0;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if ((mem_valid && i_item.mem_grant && !wait_resp) || r_second) n_pend = mem_addr;
    end

    always_comb begin
        n_second = r_second;
        n_cur    = r_cur;
        if (fire) begin
            n_second = (i_item.fetch_addr[OFF_W-1:1] == SEL_STRADDLE) && !hit0 && !hit1
                       && !r_second;
            if (!r_second) n_cur = i_item.fetch_addr;
        end
    end

    // last-line reuse: keep slot 1 when it still serves the word in flight
    always_comb begin
        reuse = 1'b0;
        if (i_item.fetch_resp_ready) begin
            if (((m1[0] || m1[1]) && req_valid)
                && (r_tag[1] != i_item.fetch_addr[ADDR_W-1:OFF_W])) begin
                reuse = need_mem;
            end
        end else begin
            if ((m1[2] || m1[3]) && !(m0[2] || m0[3]) && (r_tag[1] != pend_tag)) begin
                reuse = 1'b1;
            end
        end
    end

    always_comb begin
        n_tag[0]  = r_tag[0];
        n_tag[1]  = r_tag[1];
        n_word[0] = r_word[0];
        n_word[1] = r_word[1];
        if (i_item.mem_resp_valid) begin
            if (!reuse) begin
                n_tag[1]  = r_tag[0];
                n_word[1] = r_word[0];
            end
            n_tag[0]  = pend_tag;
            n_word[0] = i_item.mem_resp_data;
        end
    end

    always_comb begin
        o_item.fetch_ready   = fready;
        o_item.mem_req_valid = mem_valid;
        o_item.mem_req_addr  = mem_addr;
        o_item.resp_valid    = (r_state == ST_WAIT_ACCEPT) ? !r_second
                                                           : (i_item.mem_resp_valid && !r_second);
        o_item.resp_data     = r_held_vld ? r_held_word
                                          : pick_word(ld[2], ld[3], r_cur[OFF_W-1:1]);
        o_item.resp_addr     = r_cur;
        o_item.fsm_state     = r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0]    <= TAG_RESET;
            r_tag[1]    <= TAG_RESET;
            r_word[0]   <= '0;
            r_word[1]   <= '0;
            r_pend      <= '0;
            r_cur       <= '0;
            r_state     <= ST_IDLE;
            r_second    <= 1'b0;
            r_held_vld  <= 1'b0;
            r_held_word <= '0;
        end else if (i_en) begin
            r_tag[0]    <= n_tag[0];
            r_tag[1]    <= n_tag[1];
            r_word[0]   <= n_word[0];
            r_word[1]   <= n_word[1];
            r_pend      <= n_pend;
            r_cur       <= n_cur;
            r_state     <= n_state;
            r_second    <= n_second;
            r_held_vld  <= n_held_vld;
            r_held_word <= n_held_word;
        end
    end

    a_mem_fire_needs_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && mem_valid && fready |-> i_item.mem_grant)
        else $error("request accepted while a memory miss had no grant");

    a_served_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && req_valid && !need_mem |=> r_held_vld)
        else $error("word served from the lines was not held");

    a_second_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_second && fire |=> !r_second)
        else $error("second line request repeated");

endmodule

@@ sv/two_line_fetch_buffer_icache_unit.sv @@
// Two-line instruction fetch buffer. One transfer in is one clock tick of the fetch
// path (fetch request, memory grant and line, fetcher ready); one transfer out carries
// that tick's handshake outputs and instruction word. Items are taken one per cycle
// while the output side does not stall: a transfer waits in the input register, the
// line store and state machine advance as it moves to the result register, and the
// result is presented from the result register. Back pressure from the output side
// stalls the input register.
// depends on fbuf_pkg and fbuf_core
module two_line_fetch_buffer_icache_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fbuf_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fbuf_pkg::t_out_item  o_out_item
);
    import fbuf_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    logic      n_in_vld;
    logic      n_out_vld;
    logic      step_en;
    logic      in_take;
    t_out_item step_item;

    // the item in the input register moves on when the result slot is free or draining
    assign step_en    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !step_en;
    assign in_take    = i_in_valid && !o_in_stall;

    assign n_in_vld  = in_take || (r_in_vld && !step_en);
    assign n_out_vld = step_en || (r_out_vld && i_out_stall);

    fbuf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step_en),
        .i_item  (r_in_item),
        .o_item  (step_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_item <= i_in_item;
        if (step_en) r_out_item <= step_item;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en |=> r_out_vld)
        else $error("processed item did not reach the result register");

    a_stall_keeps_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !step_en |=> r_in_vld && $stable(r_in_item))
        else $error("waiting input item lost");

    a_stall_keeps_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |=> r_out_vld && $stable(r_out_item))
        else $error("stalled result changed");

endmodule
